### rtl/rv2m_pkg.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix: shared package
// Word widths, fixed-point constants, default parameter values and the
// record that travels through the sine and cosine series stages.
// ----------------------------------------------------------------------------
package rv2m_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int WORK_FRAC = 60;

  localparam logic [63:0] ONE_W     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_W = 64'h1921_FB54_442D_1846;

  localparam int IN_FRAC_BITS_DEF  = 28;
  localparam int OUT_FRAC_BITS_DEF = 30;

  localparam int ROOT_STEPS   = 32;
  localparam int AXIS_STEPS   = 60;
  localparam int ANGLE_BITS   = 32;
  localparam int TAYLOR_TERMS = 12;

  // Values in Q.60, held as two's complement bit patterns.
  typedef struct packed {
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    logic [1:0]  quad;
    logic [63:0] r2;
    logic [63:0] acc_s;
    logic [63:0] acc_c;
    logic [63:0] x_s;
    logic [63:0] x_c;
  } tr_t;

endpackage

### rtl/rv2m_mul64.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix: pipelined 64 x 64 multiplier lanes
// Each lane forms the full 128-bit unsigned product in two stages: four
// 32 x 32 partial products, then their sum. A sideband word travels along.
// ----------------------------------------------------------------------------
module rv2m_mul64 #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [LANES-1:0][rv2m_pkg::WORD_W-1:0] a,
  input  logic [LANES-1:0][rv2m_pkg::WORD_W-1:0] b,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic [LANES-1:0][2*rv2m_pkg::WORD_W-1:0] prod,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int HW = rv2m_pkg::HALF_W;
  localparam int WW = rv2m_pkg::WORD_W;

  logic [LANES-1:0][3:0][WW-1:0]   pp_r;
  logic [SIDE_W-1:0]               side1_r;
  logic                            vld1_r;
  logic [LANES-1:0][2*WW-1:0]      prod_r;
  logic [SIDE_W-1:0]               side2_r;
  logic                            vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side_in;
    side2_r <= side1_r;
    for (int l = 0; l < LANES; l++) begin
      pp_r[l][0] <= a[l][HW-1:0]  * b[l][HW-1:0];
      pp_r[l][1] <= a[l][WW-1:HW] * b[l][HW-1:0];
      pp_r[l][2] <= a[l][HW-1:0]  * b[l][WW-1:HW];
      pp_r[l][3] <= a[l][WW-1:HW] * b[l][WW-1:HW];
      prod_r[l]  <= {{WW{1'b0}}, pp_r[l][0]}
                  + {{HW{1'b0}}, pp_r[l][1], {HW{1'b0}}}
                  + {{HW{1'b0}}, pp_r[l][2], {HW{1'b0}}}
                  + {pp_r[l][3], {WW{1'b0}}};
    end
  end

  assign out_valid = vld2_r;
  assign prod      = prod_r;
  assign side_out  = side2_r;

endmodule

### rtl/rotation_vector_to_matrix.sv
// ----------------------------------------------------------------------------
// Rotation vector to rotation matrix (Rodrigues formula, fixed point)
// Throughput: one vector per clock cycle, every cycle; the 32-step root,
// the 60-step axis division and the twelve-term series are all laid out
// as register stages. busy is never raised. Reset clears only the valid
// bits of the pipeline; no result follows a reset.
// ----------------------------------------------------------------------------
module rotation_vector_to_matrix #(
  parameter int IN_FRAC_BITS  = rv2m_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = rv2m_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic               out_valid,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22
);

  localparam int ROOT_STEPS = rv2m_pkg::ROOT_STEPS;
  localparam int AXIS_STEPS = rv2m_pkg::AXIS_STEPS;
  localparam int ANGLE_BITS = rv2m_pkg::ANGLE_BITS;
  localparam int TERMS      = rv2m_pkg::TAYLOR_TERMS;
  localparam int WF         = rv2m_pkg::WORK_FRAC;
  localparam logic [63:0] ONE_W   = rv2m_pkg::ONE_W;
  localparam logic [63:0] HALF_PI = rv2m_pkg::HALF_PI_W;

  // Weight of one input LSB of the angle when it is carried in Q.60.
  localparam logic [63:0] RED_LSB = 64'd1 << (WF - IN_FRAC_BITS);

  // Output conversion: rounding shift or left shift from Q.60.
  localparam int RND_SH = (OUT_FRAC_BITS <= WF) ? WF - OUT_FRAC_BITS : 0;
  localparam int LSH_SH = (OUT_FRAC_BITS > WF) ? OUT_FRAC_BITS - WF : 0;
  localparam logic [63:0] RND_ADD = (64'd1 << RND_SH) >> 1;

  localparam logic [64:0] TWO64 = {1'b1, 64'd0};
  localparam int TR_W = $bits(rv2m_pkg::tr_t);

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [63:0]      n;
    logic [63:0]      res;
  } sq_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [31:0]      a;
    logic [2:0][31:0] rem;
    logic [2:0][60:0] quo;
    logic [63:0]      r;
    logic [1:0]       quad;
  } dv_t;

  typedef struct packed {
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] t;
  } mx_t;

  typedef struct packed {
    logic [63:0] c;
    logic [63:0] t;
    logic [8:0]  neg;
  } l1_t;

  typedef struct packed {
    logic [63:0] pxx;
    logic [63:0] pyy;
    logic [63:0] pzz;
    logic [63:0] sax;
    logic [63:0] say;
    logic [63:0] saz;
    logic [5:0]  neg;
  } l2_t;

  // Magnitude of a two's complement word, and the inverse.
  function automatic logic [63:0] umag(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] apply_sign(input logic neg, input logic [63:0] m);
    return neg ? (~m + 64'd1) : m;
  endfunction

  // Saturate to one, round half away from zero, clamp to 32 bits.
  function automatic logic [31:0] to_out(input logic [63:0] x);
    logic        neg;
    logic [63:0] m;
    logic [64:0] rd;
    logic [63:0] res;
    neg = x[63];
    m   = umag(x);
    if (m > ONE_W) m = ONE_W;
    rd  = ({1'b0, m} + {1'b0, RND_ADD}) >> RND_SH;
    m   = rd[63:0] << LSH_SH;
    if (!neg && m > 64'h0000_0000_7FFF_FFFF) m = 64'h0000_0000_7FFF_FFFF;
    if (neg && m > 64'h0000_0000_8000_0000) m = 64'h0000_0000_8000_0000;
    res = apply_sign(neg, m);
    return res[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Input register: a transfer happens whenever start is high, since the
  // pipeline never stalls. Component magnitudes and signs are split here.
  // --------------------------------------------------------------------------
  logic             accept;
  logic [2:0][31:0] in_raw;
  logic [2:0][31:0] in_mag;
  logic [2:0]       in_neg;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign in_raw = {in_vec_z, in_vec_y, in_vec_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_neg[i] = in_raw[i][31];
      in_mag[i] = in_raw[i][31] ? (~in_raw[i] + 32'd1) : in_raw[i];
    end
  end

  logic             f0_vld_r, f1_vld_r;
  logic [2:0][31:0] f0_mag_r, f1_mag_r;
  logic [2:0]       f0_neg_r, f1_neg_r;
  logic [2:0][63:0] f1_sq_r;

  sq_t  sq_r   [0:ROOT_STEPS];
  sq_t  sq_nxt [1:ROOT_STEPS];
  logic sq_vld_r [0:ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r    <= 1'b0;
      f1_vld_r    <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else begin
      f0_vld_r    <= accept;
      f1_vld_r    <= f0_vld_r;
      sq_vld_r[0] <= f1_vld_r;
    end
  end

  // Squares in one stage, their sum in the next.
  always_ff @(posedge clk) begin
    f0_mag_r <= in_mag;
    f0_neg_r <= in_neg;
    f1_mag_r <= f0_mag_r;
    f1_neg_r <= f0_neg_r;
    for (int i = 0; i < 3; i++) begin
      f1_sq_r[i] <= f0_mag_r[i] * f0_mag_r[i];
    end
    sq_r[0].mag <= f1_mag_r;
    sq_r[0].neg <= f1_neg_r;
    sq_r[0].n   <= f1_sq_r[0] + f1_sq_r[1] + f1_sq_r[2];
    sq_r[0].res <= 64'd0;
  end

  // --------------------------------------------------------------------------
  // Integer square root of the sum: one bit pair per stage, starting from
  // the top pair. Leading zero pairs merely shift a zero result, so the
  // result is the floored root without a separate leading-pair search.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * g);

    always_comb begin
      sq_nxt[g+1] = sq_r[g];
      if (sq_r[g].n >= sq_r[g].res + SQ_BIT) begin
        sq_nxt[g+1].n   = sq_r[g].n - (sq_r[g].res + SQ_BIT);
        sq_nxt[g+1].res = (sq_r[g].res >> 1) + SQ_BIT;
      end else begin
        sq_nxt[g+1].res = sq_r[g].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g+1] <= 1'b0;
      end else begin
        sq_vld_r[g+1] <= sq_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      sq_r[g+1] <= sq_nxt[g+1];
    end
  end

  // --------------------------------------------------------------------------
  // Axis division and angle reduction. The first stage takes the integer
  // quotient bit (each magnitude never exceeds the angle); each later stage
  // produces one more fraction bit for all three components. While the
  // angle bits last, the same stages also fold the angle, one bit a stage,
  // modulo the truncated pi/2 and count quadrants; at most two subtractions
  // are ever needed per bit.
  // --------------------------------------------------------------------------
  dv_t  dv_r     [0:AXIS_STEPS];
  dv_t  dv_nxt   [0:AXIS_STEPS];
  logic dv_vld_r [0:AXIS_STEPS];

  always_comb begin
    dv_nxt[0].neg  = sq_r[ROOT_STEPS].neg;
    dv_nxt[0].a    = sq_r[ROOT_STEPS].res[31:0];
    dv_nxt[0].r    = 64'd0;
    dv_nxt[0].quad = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (sq_r[ROOT_STEPS].mag[i] >= sq_r[ROOT_STEPS].res[31:0]) begin
        dv_nxt[0].rem[i] = sq_r[ROOT_STEPS].mag[i] - sq_r[ROOT_STEPS].res[31:0];
        dv_nxt[0].quo[i] = 61'd1;
      end else begin
        dv_nxt[0].rem[i] = sq_r[ROOT_STEPS].mag[i];
        dv_nxt[0].quo[i] = 61'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sq_vld_r[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= dv_nxt[0];
  end

  for (genvar j = 1; j <= AXIS_STEPS; j++) begin : g_axis
    localparam int RED_BIT = (j <= ANGLE_BITS) ? ANGLE_BITS - j : 0;

    logic [32:0] rem2 [3];
    logic [63:0] r_sh;
    logic [1:0]  q_sh;

    always_comb begin
      dv_nxt[j] = dv_r[j-1];
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {dv_r[j-1].rem[i], 1'b0};
        if (rem2[i] >= {1'b0, dv_r[j-1].a}) begin
          rem2[i]          = rem2[i] - {1'b0, dv_r[j-1].a};
          dv_nxt[j].quo[i] = {dv_r[j-1].quo[i][59:0], 1'b1};
        end else begin
          dv_nxt[j].quo[i] = {dv_r[j-1].quo[i][59:0], 1'b0};
        end
        dv_nxt[j].rem[i] = rem2[i][31:0];
      end
      r_sh = (dv_r[j-1].r << 1) + (dv_r[j-1].a[RED_BIT] ? RED_LSB : 64'd0);
      q_sh = {dv_r[j-1].quad[0], 1'b0};
      if (j <= ANGLE_BITS) begin
        if (r_sh >= (HALF_PI << 1)) begin
          dv_nxt[j].r    = r_sh - (HALF_PI << 1);
          dv_nxt[j].quad = q_sh + 2'd2;
        end else if (r_sh >= HALF_PI) begin
          dv_nxt[j].r    = r_sh - HALF_PI;
          dv_nxt[j].quad = q_sh + 2'd1;
        end else begin
          dv_nxt[j].r    = r_sh;
          dv_nxt[j].quad = q_sh;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else begin
        dv_vld_r[j] <= dv_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_r[j] <= dv_nxt[j];
    end
  end

  // --------------------------------------------------------------------------
  // Series set-up: signed axis (zero for a zero vector), then r squared.
  // A zero vector leaves r at zero, so the series give s = 0 and c = 1.
  // --------------------------------------------------------------------------
  rv2m_pkg::tr_t       tr_in;
  rv2m_pkg::tr_t       r2_side;
  logic [0:0][127:0]   r2_prod;
  logic                r2_vld;
  logic                dv_zero;
  logic [2:0][63:0]    axis_w;

  rv2m_pkg::tr_t       tr_w   [0:TERMS];
  logic                tr_vld [0:TERMS];

  assign dv_zero = (dv_r[AXIS_STEPS].a == 32'd0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero) begin
        axis_w[i] = 64'd0;
      end else begin
        axis_w[i] = apply_sign(dv_r[AXIS_STEPS].neg[i], {3'b000, dv_r[AXIS_STEPS].quo[i]});
      end
    end
    tr_in.ax    = axis_w[0];
    tr_in.ay    = axis_w[1];
    tr_in.az    = axis_w[2];
    tr_in.quad  = dv_r[AXIS_STEPS].quad;
    tr_in.r2    = 64'd0;
    tr_in.acc_s = dv_r[AXIS_STEPS].r;
    tr_in.acc_c = ONE_W;
    tr_in.x_s   = dv_r[AXIS_STEPS].r;
    tr_in.x_c   = ONE_W;
  end

  rv2m_mul64 #(.LANES(1), .SIDE_W(TR_W)) u_mul_r2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_vld_r[AXIS_STEPS]),
    .a        (dv_r[AXIS_STEPS].r),
    .b        (dv_r[AXIS_STEPS].r),
    .side_in  (tr_in),
    .out_valid(r2_vld),
    .prod     (r2_prod),
    .side_out (r2_side)
  );

  always_comb begin
    tr_w[0]    = r2_side;
    tr_w[0].r2 = r2_prod[0][123:60];
  end
  assign tr_vld[0] = r2_vld;

  // --------------------------------------------------------------------------
  // Taylor terms, sine and cosine side by side. Each term takes six stages:
  // multiply by r squared, multiply by the reciprocal of n(n+1), then one
  // correction step that fixes the reciprocal's quotient, which is exact or
  // one short, and adds the term with its alternating sign.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < TERMS; g++) begin : g_term
    localparam int DS = (2 * g + 2) * (2 * g + 3);
    localparam int DC = (2 * g + 1) * (2 * g + 2);
    localparam logic [63:0] MS = 64'(TWO64 / 65'(DS));
    localparam logic [63:0] MC = 64'(TWO64 / 65'(DC));
    localparam logic [63:0] DS_W = 64'(DS);
    localparam logic [63:0] DC_W = 64'(DC);

    logic              ma_vld, mb_vld;
    logic [1:0][127:0] ma_prod, mb_prod;
    rv2m_pkg::tr_t     ma_side, ma_t, mb_side;

    rv2m_pkg::tr_t     t5_r;
    logic              t5_vld_r;
    logic [1:0][63:0]  t5_q0_r;
    logic [1:0][63:0]  t5_qd_r;

    rv2m_pkg::tr_t     t6_nxt, t6_r;
    logic              t6_vld_r;
    logic [63:0]       rem_s, rem_c, term_s, term_c;

    rv2m_mul64 #(.LANES(2), .SIDE_W(TR_W)) u_mul_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (tr_vld[g]),
      .a        ({tr_w[g].x_c, tr_w[g].x_s}),
      .b        ({tr_w[g].r2, tr_w[g].r2}),
      .side_in  (tr_w[g]),
      .out_valid(ma_vld),
      .prod     (ma_prod),
      .side_out (ma_side)
    );

    always_comb begin
      ma_t     = ma_side;
      ma_t.x_s = ma_prod[0][123:60];
      ma_t.x_c = ma_prod[1][123:60];
    end

    rv2m_mul64 #(.LANES(2), .SIDE_W(TR_W)) u_mul_recip (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (ma_vld),
      .a        ({ma_t.x_c, ma_t.x_s}),
      .b        ({MC, MS}),
      .side_in  (ma_t),
      .out_valid(mb_vld),
      .prod     (mb_prod),
      .side_out (mb_side)
    );

    always_comb begin
      rem_s  = t5_r.x_s - t5_qd_r[0];
      rem_c  = t5_r.x_c - t5_qd_r[1];
      term_s = (rem_s >= DS_W) ? t5_q0_r[0] + 64'd1 : t5_q0_r[0];
      term_c = (rem_c >= DC_W) ? t5_q0_r[1] + 64'd1 : t5_q0_r[1];
      t6_nxt     = t5_r;
      t6_nxt.x_s = term_s;
      t6_nxt.x_c = term_c;
      if ((g % 2) == 0) begin
        t6_nxt.acc_s = t5_r.acc_s - term_s;
        t6_nxt.acc_c = t5_r.acc_c - term_c;
      end else begin
        t6_nxt.acc_s = t5_r.acc_s + term_s;
        t6_nxt.acc_c = t5_r.acc_c + term_c;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        t5_vld_r <= 1'b0;
        t6_vld_r <= 1'b0;
      end else begin
        t5_vld_r <= mb_vld;
        t6_vld_r <= t5_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      t5_r       <= mb_side;
      t5_q0_r[0] <= mb_prod[0][127:64];
      t5_q0_r[1] <= mb_prod[1][127:64];
      t5_qd_r[0] <= mb_prod[0][127:64] * DS_W;
      t5_qd_r[1] <= mb_prod[1][127:64] * DC_W;
      t6_r       <= t6_nxt;
    end

    assign tr_w[g+1]   = t6_r;
    assign tr_vld[g+1] = t6_vld_r;
  end

  // --------------------------------------------------------------------------
  // Quadrant selection of sin and cos, and 1 - c.
  // --------------------------------------------------------------------------
  mx_t  mx_nxt, mx_r;
  logic mx_vld_r;

  always_comb begin
    mx_nxt.ax = tr_w[TERMS].ax;
    mx_nxt.ay = tr_w[TERMS].ay;
    mx_nxt.az = tr_w[TERMS].az;
    case (tr_w[TERMS].quad)
      2'd0: begin
        mx_nxt.s = tr_w[TERMS].acc_s;
        mx_nxt.c = tr_w[TERMS].acc_c;
      end
      2'd1: begin
        mx_nxt.s = tr_w[TERMS].acc_c;
        mx_nxt.c = ~tr_w[TERMS].acc_s + 64'd1;
      end
      2'd2: begin
        mx_nxt.s = ~tr_w[TERMS].acc_s + 64'd1;
        mx_nxt.c = ~tr_w[TERMS].acc_c + 64'd1;
      end
      default: begin
        mx_nxt.s = ~tr_w[TERMS].acc_c + 64'd1;
        mx_nxt.c = tr_w[TERMS].acc_s;
      end
    endcase
    mx_nxt.t = ONE_W - mx_nxt.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mx_vld_r <= 1'b0;
    end else begin
      mx_vld_r <= tr_vld[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
  end

  // --------------------------------------------------------------------------
  // First product level: axis squares, axis cross products and s times
  // each axis component, as magnitudes with the sign kept aside.
  // --------------------------------------------------------------------------
  logic [8:0][63:0]  l1_a, l1_b;
  l1_t               l1_in, l1_side;
  logic [8:0][127:0] l1_prod;
  logic              l1_vld;

  always_comb begin
    l1_a[0] = umag(mx_r.ax); l1_b[0] = umag(mx_r.ax);
    l1_a[1] = umag(mx_r.ay); l1_b[1] = umag(mx_r.ay);
    l1_a[2] = umag(mx_r.az); l1_b[2] = umag(mx_r.az);
    l1_a[3] = umag(mx_r.ax); l1_b[3] = umag(mx_r.ay);
    l1_a[4] = umag(mx_r.ax); l1_b[4] = umag(mx_r.az);
    l1_a[5] = umag(mx_r.ay); l1_b[5] = umag(mx_r.az);
    l1_a[6] = umag(mx_r.s);  l1_b[6] = umag(mx_r.ax);
    l1_a[7] = umag(mx_r.s);  l1_b[7] = umag(mx_r.ay);
    l1_a[8] = umag(mx_r.s);  l1_b[8] = umag(mx_r.az);
    l1_in.c      = mx_r.c;
    l1_in.t      = mx_r.t;
    l1_in.neg[0] = 1'b0;
    l1_in.neg[1] = 1'b0;
    l1_in.neg[2] = 1'b0;
    l1_in.neg[3] = mx_r.ax[63] ^ mx_r.ay[63];
    l1_in.neg[4] = mx_r.ax[63] ^ mx_r.az[63];
    l1_in.neg[5] = mx_r.ay[63] ^ mx_r.az[63];
    l1_in.neg[6] = mx_r.s[63] ^ mx_r.ax[63];
    l1_in.neg[7] = mx_r.s[63] ^ mx_r.ay[63];
    l1_in.neg[8] = mx_r.s[63] ^ mx_r.az[63];
  end

  rv2m_mul64 #(.LANES(9), .SIDE_W($bits(l1_t))) u_mul_lvl1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mx_vld_r),
    .a        (l1_a),
    .b        (l1_b),
    .side_in  (l1_in),
    .out_valid(l1_vld),
    .prod     (l1_prod),
    .side_out (l1_side)
  );

  logic [8:0][63:0] p_r;
  logic [63:0]      pc_r, pt_r;
  logic             p_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= l1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      p_r[i] <= apply_sign(l1_side.neg[i], l1_prod[i][123:60]);
    end
    pc_r <= l1_side.c;
    pt_r <= l1_side.t;
  end

  // --------------------------------------------------------------------------
  // Second product level: c * (1 - axis square) on the diagonal and the
  // cross products times (1 - c) off it.
  // --------------------------------------------------------------------------
  logic [2:0][63:0]  om;
  logic [5:0][63:0]  l2_a, l2_b;
  l2_t               l2_in, l2_side;
  logic [5:0][127:0] l2_prod;
  logic              l2_vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      om[i]           = ONE_W - p_r[i];
      l2_a[i]         = umag(pc_r);
      l2_b[i]         = umag(om[i]);
      l2_in.neg[i]    = pc_r[63] ^ om[i][63];
      l2_a[i+3]       = umag(p_r[i+3]);
      l2_b[i+3]       = umag(pt_r);
      l2_in.neg[i+3]  = p_r[i+3][63] ^ pt_r[63];
    end
    l2_in.pxx = p_r[0];
    l2_in.pyy = p_r[1];
    l2_in.pzz = p_r[2];
    l2_in.sax = p_r[6];
    l2_in.say = p_r[7];
    l2_in.saz = p_r[8];
  end

  rv2m_mul64 #(.LANES(6), .SIDE_W($bits(l2_t))) u_mul_lvl2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (p_vld_r),
    .a        (l2_a),
    .b        (l2_b),
    .side_in  (l2_in),
    .out_valid(l2_vld),
    .prod     (l2_prod),
    .side_out (l2_side)
  );

  // --------------------------------------------------------------------------
  // Matrix entries in Q.60, then conversion to the output format.
  // --------------------------------------------------------------------------
  logic [5:0][63:0] q2;
  logic [8:0][63:0] m_nxt, m_r;
  logic             m_vld_r;
  logic [8:0][31:0] out_m_r;
  logic             out_vld_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      q2[i] = apply_sign(l2_side.neg[i], l2_prod[i][123:60]);
    end
    m_nxt[0] = l2_side.pxx + q2[0];
    m_nxt[4] = l2_side.pyy + q2[1];
    m_nxt[8] = l2_side.pzz + q2[2];
    m_nxt[1] = q2[3] + l2_side.saz;
    m_nxt[3] = q2[3] - l2_side.saz;
    m_nxt[2] = q2[4] - l2_side.say;
    m_nxt[6] = q2[4] + l2_side.say;
    m_nxt[5] = q2[5] + l2_side.sax;
    m_nxt[7] = q2[5] - l2_side.sax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      m_vld_r   <= l2_vld;
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    for (int i = 0; i < 9; i++) begin
      out_m_r[i] <= to_out(m_r[i]);
    end
  end

  assign out_valid = out_vld_r;
  assign out_m00   = out_m_r[0];
  assign out_m01   = out_m_r[1];
  assign out_m02   = out_m_r[2];
  assign out_m10   = out_m_r[3];
  assign out_m11   = out_m_r[4];
  assign out_m12   = out_m_r[5];
  assign out_m20   = out_m_r[6];
  assign out_m21   = out_m_r[7];
  assign out_m22   = out_m_r[8];

endmodule

### tb/rotation_vector_to_matrix_tb.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix: self-checking testbench
// A short table of directed vectors (zero, extremes, axis-aligned and
// quadrant-boundary angles) is followed by random vectors, some wide-range,
// some small, some near multiples of pi/2. Zero is checked against identity;
// every other result is compared, entry by entry, with a bit-exact fixed-point
// predictor of the Rodrigues matrix in the block's sign convention.
// ----------------------------------------------------------------------------
module rotation_vector_to_matrix_tb;

  // Nine entries, row-major, entry 0 in the low word.
  typedef logic [8:0][31:0] matrix_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    matrix_t            m;
  } vec_row_t;

  localparam int          RANDOM_VECTORS = 1600;
  localparam int          STALL_LIMIT    = 5000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          OUT_SHIFT      = rv2m_pkg::WORK_FRAC - rv2m_pkg::OUT_FRAC_BITS_DEF;
  localparam int          ANGLE_SHIFT    = rv2m_pkg::WORK_FRAC - rv2m_pkg::IN_FRAC_BITS_DEF;
  localparam logic [31:0] Q30_ONE        = 32'h4000_0000;
  localparam logic [31:0] S32_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN        = 32'h8000_0000;
  // pi/2 in the input's Q4.28 format.
  localparam int          QUARTER_TURN   = 421657428;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_vec_x;
  logic signed [31:0] in_vec_y;
  logic signed [31:0] in_vec_z;
  logic               out_valid;
  logic signed [31:0] out_m00, out_m01, out_m02;
  logic signed [31:0] out_m10, out_m11, out_m12;
  logic signed [31:0] out_m20, out_m21, out_m22;

  // Typed expectation travelling alongside a directed vector.
  bit      typed_pending;
  matrix_t typed_matrix;

  matrix_t pending_matrices[$];
  int      transfers_in;
  int      stall_cycles;
  bit      failed;
  bit      allow_gaps;

  rotation_vector_to_matrix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_vec_z  (in_vec_z),
    .out_valid (out_valid),
    .out_m00   (out_m00),
    .out_m01   (out_m01),
    .out_m02   (out_m02),
    .out_m10   (out_m10),
    .out_m11   (out_m11),
    .out_m12   (out_m12),
    .out_m20   (out_m20),
    .out_m21   (out_m21),
    .out_m22   (out_m22)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor. All working values are Q.60 bit patterns.
  // --------------------------------------------------------------------------

  // floor(x * y / 2^60) on unsigned operands.
  function automatic logic [63:0] umul_q60(logic [63:0] x, logic [63:0] y);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return prod[123:60];
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Signed product: magnitudes multiplied and truncated, sign applied after.
  function automatic logic [63:0] smul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = umul_q60(magnitude(a), magnitude(b));
    return (a[63] ^ b[63]) ? -m : m;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n    = n - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // Alternating Taylor sum; first term given, each next one scaled by r^2 and divided by n(n+1).
  function automatic logic [63:0] taylor_sum(logic [63:0] first, logic [63:0] r_sq,
                                             int unsigned n0);
    logic [63:0] term;
    logic [63:0] acc;
    int unsigned n;
    term = first;
    acc  = first;
    n    = n0;
    for (int k = 1; k <= rv2m_pkg::TAYLOR_TERMS; k++) begin
      term = umul_q60(term, r_sq) / (64'(n) * 64'(n + 1));
      acc  = (k % 2 == 1) ? acc - term : acc + term;
      n    = n + 2;
    end
    return acc;
  endfunction

  // Saturate to plus or minus one, round half away from zero to Q2.30.
  function automatic logic [31:0] to_q2_30(logic [63:0] v);
    logic [63:0] m;
    m = magnitude(v);
    if (m > rv2m_pkg::ONE_W) m = rv2m_pkg::ONE_W;
    m = (m + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (!v[63] && m > 64'(S32_MAX)) m = 64'(S32_MAX);
    if (v[63] && m > 64'(S32_MIN)) m = 64'(S32_MIN);
    m = v[63] ? -m : m;
    return m[31:0];
  endfunction

  function automatic matrix_t rodrigues_matrix(logic signed [31:0] vx,
                                               logic signed [31:0] vy,
                                               logic signed [31:0] vz);
    logic [63:0]  comp_mag[3];
    logic [63:0]  axis[3];
    logic [63:0]  sum_sq;
    logic [63:0]  angle;
    logic [127:0] scaled;
    logic [63:0]  r;
    logic [63:0]  r_sq;
    logic [63:0]  sin_r;
    logic [63:0]  cos_r;
    logic [1:0]   quad;
    logic [63:0]  s;
    logic [63:0]  c;
    logic [63:0]  t;
    logic [63:0]  p;
    logic [63:0]  w[9];
    matrix_t      res;
    comp_mag[0] = vx[31] ? 64'(-64'(vx)) : 64'(vx);
    comp_mag[1] = vy[31] ? 64'(-64'(vy)) : 64'(vy);
    comp_mag[2] = vz[31] ? 64'(-64'(vz)) : 64'(vz);
    sum_sq = comp_mag[0] * comp_mag[0] + comp_mag[1] * comp_mag[1]
           + comp_mag[2] * comp_mag[2];
    angle = floor_sqrt(sum_sq);
    s = '0;
    c = rv2m_pkg::ONE_W;
    foreach (axis[i]) axis[i] = '0;
    if (angle != 0) begin
      // Unit axis: floor(|v| * 2^60 / angle), sign of the component.
      foreach (axis[i]) begin
        scaled  = ({64'd0, comp_mag[i]} << rv2m_pkg::WORK_FRAC) / {64'd0, angle};
        axis[i] = scaled[63:0];
      end
      if (vx[31]) axis[0] = -axis[0];
      if (vy[31]) axis[1] = -axis[1];
      if (vz[31]) axis[2] = -axis[2];
      // Exact reduction of the angle by the truncated pi/2.
      scaled = {64'd0, angle} << ANGLE_SHIFT;
      r      = 64'(scaled % {64'd0, rv2m_pkg::HALF_PI_W});
      quad   = 2'(scaled / {64'd0, rv2m_pkg::HALF_PI_W});
      r_sq   = umul_q60(r, r);
      sin_r  = taylor_sum(r, r_sq, 2);
      cos_r  = taylor_sum(rv2m_pkg::ONE_W, r_sq, 1);
      case (quad)
        2'd0: begin s = sin_r;  c = cos_r;  end
        2'd1: begin s = cos_r;  c = -sin_r; end
        2'd2: begin s = -sin_r; c = -cos_r; end
        default: begin s = -cos_r; c = sin_r; end
      endcase
    end
    t = rv2m_pkg::ONE_W - c;
    for (int i = 0; i < 3; i++) begin
      p = smul_q60(axis[i], axis[i]);
      w[4 * i] = p + smul_q60(c, rv2m_pkg::ONE_W - p);
    end
    p    = smul_q60(smul_q60(axis[0], axis[1]), t);
    w[1] = p + smul_q60(s, axis[2]);
    w[3] = p - smul_q60(s, axis[2]);
    p    = smul_q60(smul_q60(axis[0], axis[2]), t);
    w[2] = p - smul_q60(s, axis[1]);
    w[6] = p + smul_q60(s, axis[1]);
    p    = smul_q60(smul_q60(axis[1], axis[2]), t);
    w[5] = p + smul_q60(s, axis[0]);
    w[7] = p - smul_q60(s, axis[0]);
    for (int i = 0; i < 9; i++) res[i] = to_q2_30(w[i]);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Every value is read before this edge's nonblocking updates land,
  // so an input transfer and a result transfer are both seen as they stood
  // during the cycle that the edge closes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    matrix_t want;
    matrix_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n && out_valid) begin
      moved = 1'b1;
      got = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
             out_m02, out_m01, out_m00};
      if (pending_matrices.size() == 0) begin
        $display("%0t: result with no vector outstanding, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: m%0d%0d expected %h actual %h",
                     $time, i / 3, i % 3, want[i], got[i]);
            failed = 1'b1;
          end
        end
      end
    end
    if (rst_n && start && !busy) begin
      moved = 1'b1;
      // Directed rows with a typed answer bypass the predictor.
      if (typed_pending) pending_matrices.push_back(typed_matrix);
      else pending_matrices.push_back(rodrigues_matrix(in_vec_x, in_vec_y, in_vec_z));
      transfers_in++;
    end
    // The watchdog only runs once reset is over and counts dead cycles.
    if (!rst_n || moved) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. A vector is presented with start high and held until the monitor
  // has counted its transfer; gaps are inserted beforehand at random.
  // --------------------------------------------------------------------------
  task automatic send_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, bit typed, matrix_t m);
    int seen;
    while (allow_gaps && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    seen = transfers_in;
    in_vec_x      <= vx;
    in_vec_y      <= vy;
    in_vec_z      <= vz;
    typed_pending <= typed;
    typed_matrix  <= m;
    start         <= 1'b1;
    @(posedge clk);
    wait (transfers_in != seen);
  endtask

  function automatic logic signed [31:0] random_component(int unsigned kind);
    logic signed [31:0] v;
    v = $urandom;
    case (kind)
      0: return v;
      1: return v >>> $urandom_range(31);
      2: return $urandom_range(1) ? S32_MAX : S32_MIN;
      default: return 32'sd0;
    endcase
  endfunction

  vec_row_t directed_rows[$];

  initial begin
    matrix_t            identity;
    matrix_t            none;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    int unsigned        pick;
    identity = '0;
    identity[0] = Q30_ONE;
    identity[4] = Q30_ONE;
    identity[8] = Q30_ONE;
    none = '0;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_vec_x      = '0;
    in_vec_y      = '0;
    in_vec_z      = '0;
    typed_pending = 1'b0;
    typed_matrix  = '0;
    transfers_in  = 0;
    stall_cycles  = 0;
    failed        = 1'b0;
    allow_gaps    = 1'b1;

    // The zero vector gives the identity; everything else is predicted.
    directed_rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, identity},
      '{S32_MAX, 32'sd0, 32'sd0, 1'b0, none},
      '{S32_MIN, 32'sd0, 32'sd0, 1'b0, none},
      '{32'sd0, S32_MAX, 32'sd0, 1'b0, none},
      '{32'sd0, S32_MIN, 32'sd0, 1'b0, none},
      '{32'sd0, 32'sd0, S32_MAX, 1'b0, none},
      '{32'sd0, 32'sd0, S32_MIN, 1'b0, none},
      '{S32_MAX, S32_MAX, S32_MAX, 1'b0, none},
      '{S32_MIN, S32_MIN, S32_MIN, 1'b0, none},
      '{S32_MIN, S32_MAX, S32_MIN, 1'b0, none},
      '{32'sd1, 32'sd0, 32'sd0, 1'b0, none},
      '{-32'sd1, 32'sd0, 32'sd0, 1'b0, none},
      '{32'sd0, 32'sd0, 32'sd1, 1'b0, none},
      '{32'sd1, -32'sd1, 32'sd1, 1'b0, none},
      '{32'(QUARTER_TURN), 32'sd0, 32'sd0, 1'b0, none},
      '{32'sd0, 32'(2 * QUARTER_TURN), 32'sd0, 1'b0, none},
      '{32'sd0, 32'sd0, 32'(3 * QUARTER_TURN), 1'b0, none},
      '{32'(4 * QUARTER_TURN), 32'sd0, 32'sd0, 1'b0, none},
      '{32'sd0, -32'(QUARTER_TURN), 32'sd0, 1'b0, none},
      '{32'sd268435456, -32'sd536870912, 32'sd805306368, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].typed, directed_rows[i].m);

    // Let the pipeline run dry once before the random part.
    start <= 1'b0;
    @(posedge clk);
    wait (pending_matrices.size() == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      // A long run of back-to-back transfers in the middle.
      allow_gaps = !(n >= 600 && n < 900);
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3: begin
          vx = random_component(0);
          vy = random_component(0);
          vz = random_component(0);
        end
        4, 5: begin
          vx = random_component(1);
          vy = random_component(1);
          vz = random_component(1);
        end
        6: begin
          // One axis only, any magnitude.
          vx = '0;
          vy = '0;
          vz = '0;
          case ($urandom_range(2))
            0: vx = random_component($urandom_range(1));
            1: vy = random_component($urandom_range(1));
            default: vz = random_component($urandom_range(1));
          endcase
        end
        7: begin
          // Close to a quadrant boundary of the angle.
          vx = 32'($urandom_range(5) * QUARTER_TURN) + 32'($signed($urandom_range(64)) - 32);
          vy = 32'($signed($urandom_range(16)) - 8);
          vz = '0;
          if ($urandom_range(1)) vx = -vx;
        end
        8: begin
          vx = random_component($urandom_range(2));
          vy = random_component(2);
          vz = random_component($urandom_range(3));
        end
        default: begin
          vx = random_component(3);
          vy = random_component(1);
          vz = random_component($urandom_range(1, 3));
        end
      endcase
      send_vector(vx, vy, vz, 1'b0, none);
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending_matrices.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && pending_matrices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
